[rtl/core/mfm_flux_interval_decoder_macros.svh]
// Assertion helpers shared by the decoder RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef MFM_FLUX_INTERVAL_DECODER_MACROS_SVH
`define MFM_FLUX_INTERVAL_DECODER_MACROS_SVH

// Same-cycle implication
`define MFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mfd_pkg.sv]
package mfd_pkg;

  localparam int unsigned StampW = 16;
  localparam int unsigned CodeBits = 2;
  localparam int unsigned ByteBits = 8;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_TOO_SHORT = 2'd0,
    CFG_LIMIT_4US = 2'd1,
    CFG_LIMIT_6US = 2'd2,
    CFG_LIMIT_8US = 2'd3
  } cfg_idx_e;

  // Cell codes
  typedef enum logic [CodeBits-1:0] {
    CODE_NONE = 2'd0,
    CODE_4US  = 2'd1,
    CODE_6US  = 2'd2,
    CODE_8US  = 2'd3
  } code_e;

  localparam logic [StampW-1:0] TooShortReset = 16'd22;
  localparam logic [StampW-1:0] Limit4usReset = 16'd40;
  localparam logic [StampW-1:0] Limit6usReset = 16'd56;
  localparam logic [StampW-1:0] Limit8usReset = 16'd72;

  typedef struct packed {
    logic [StampW-1:0] too_short;
    logic [StampW-1:0] limit_4us;
    logic [StampW-1:0] limit_6us;
    logic [StampW-1:0] limit_8us;
  } thresh_t;

  typedef struct packed {
    logic                symbol_valid;
    code_e               symbol_code;
    logic                byte_push;
    logic [ByteBits-1:0] packed_byte;
    logic                rx_drop;
  } result_t;

endpackage

[rtl/core/mfd_cfg.sv]
module mfd_cfg import mfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [StampW-1:0] cfg_wdata_i,
  output thresh_t           thresh_o
);

  thresh_t thresh_q;

  // Write the addressed threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.too_short <= TooShortReset;
      thresh_q.limit_4us <= Limit4usReset;
      thresh_q.limit_6us <= Limit6usReset;
      thresh_q.limit_8us <= Limit8usReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TOO_SHORT: thresh_q.too_short <= cfg_wdata_i;
        CFG_LIMIT_4US: thresh_q.limit_4us <= cfg_wdata_i;
        CFG_LIMIT_6US: thresh_q.limit_6us <= cfg_wdata_i;
        CFG_LIMIT_8US: thresh_q.limit_8us <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign thresh_o = thresh_q;

endmodule

[rtl/core/mfd_cell.sv]
module mfd_cell import mfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [StampW-1:0] stamp_i,
  input  logic              tx_full_i,
  input  logic              rx_nonempty_i,
  input  thresh_t           thresh_i,
  output result_t           result_o
);

  logic [StampW-1:0]   prev_q, prev_d;
  logic [ByteBits-1:0] acc_q, acc_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [StampW-1:0]   interval;
  code_e               code;
  logic                hit;
  logic                complete;

  // Wrapping interval since the previous pulse
  assign interval = stamp_i - prev_q;

  // Classify against the thresholds in order
  always_comb begin
    if (interval < thresh_i.too_short) begin
      code = CODE_NONE;
    end else if (interval < thresh_i.limit_4us) begin
      code = CODE_4US;
    end else if (interval < thresh_i.limit_6us) begin
      code = CODE_6US;
    end else if (interval < thresh_i.limit_8us) begin
      code = CODE_8US;
    end else begin
      code = CODE_NONE;
    end
  end

  assign hit      = (code != CODE_NONE);
  assign acc_d    = hit ? {acc_q[ByteBits-CodeBits-1:0], code} : acc_q;
  assign cnt_d    = hit ? cnt_q + 2'd1 : cnt_q;
  assign prev_d   = stamp_i;
  assign complete = hit && (cnt_q == 2'd3);

  // Build the result for this pulse
  always_comb begin
    result_o.symbol_valid = hit;
    result_o.symbol_code  = code;
    result_o.byte_push    = complete && !tx_full_i;
    result_o.packed_byte  = complete ? acc_d : '0;
    result_o.rx_drop      = complete && rx_nonempty_i;
  end

  // Advance the decoder state once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (advance_i) begin
      prev_q <= prev_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/mfm_flux_interval_decoder.sv]
// Channel | Direction | Handshake                | Payload
// input   | in        | in_valid_i / in_ready_o  | capture_stamp_i, tx_full_i, rx_nonempty_i
// result  | out       | out_valid_o / out_ready_i| symbol_*, byte_push_o, packed_byte_o, rx_drop_o
// config  | in        | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
// One request is taken per cycle while in_ready_o is high and waits in the input register,
// then moves through subtract/compare/shift into the result register when that register is free.
// Reset loads the default thresholds and clears stamp, accumulator and code count.
// While the result waits, one more request is taken into the input register;
// in_ready_o then stays low until the result is taken.
`include "mfm_flux_interval_decoder_macros.svh"

module mfm_flux_interval_decoder import mfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [StampW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [StampW-1:0]   capture_stamp_i,
  input  logic                tx_full_i,
  input  logic                rx_nonempty_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                symbol_valid_o,
  output logic [CodeBits-1:0] symbol_code_o,
  output logic                byte_push_o,
  output logic [ByteBits-1:0] packed_byte_o,
  output logic                rx_drop_o
);

  thresh_t           thresh;
  logic              in_vld_q;
  logic [StampW-1:0] stamp_q;
  logic              tx_full_q;
  logic              rx_ne_q;
  logic              out_vld_q;
  result_t           res_q;
  result_t           res_d;
  logic              out_free;
  logic              advance;
  logic              in_fire;

  mfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thresh_o    (thresh)
  );

  // Pipeline control
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Hold the input request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stamp_q   <= capture_stamp_i;
      tx_full_q <= tx_full_i;
      rx_ne_q   <= rx_nonempty_i;
    end
  end

  mfd_cell u_cell (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .stamp_i       (stamp_q),
    .tx_full_i     (tx_full_q),
    .rx_nonempty_i (rx_ne_q),
    .thresh_i      (thresh),
    .result_o      (res_d)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign symbol_valid_o = res_q.symbol_valid;
  assign symbol_code_o  = res_q.symbol_code;
  assign byte_push_o    = res_q.byte_push;
  assign packed_byte_o  = res_q.packed_byte;
  assign rx_drop_o      = res_q.rx_drop;

  `MFD_ASSERT_NEXT(a_advance_fills, advance, out_vld_q, "advanced request did not reach output")
  `MFD_ASSERT_NOW(a_full_drains, in_vld_q && in_ready_o, advance, "input taken while held request stuck")
  `MFD_ASSERT_NOW(a_byte_needs_code, out_vld_q && (byte_push_o || rx_drop_o), symbol_valid_o, "byte event without code")
  `MFD_ASSERT_NOW(a_code_none, out_vld_q && !symbol_valid_o, symbol_code_o == CODE_NONE && packed_byte_o == '0, "ignored interval carries data")

endmodule
